// ----- rtl/sequenced_history_ring_pager_macros.svh -----
// assertion macros for the history ring pager, expanded empty for synthesis
`ifndef SEQUENCED_HISTORY_RING_PAGER_MACROS_SVH
`define SEQUENCED_HISTORY_RING_PAGER_MACROS_SVH
`ifndef SYNTHESIS
// plain condition checked at every clock edge out of reset
`define SHRP_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("history ring pager check failed");
// same-cycle implication
`define SHRP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("history ring pager implication failed");
// next-cycle implication
`define SHRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("history ring pager sequence failed");
`else
`define SHRP_ASSERT(label, cond)
`define SHRP_ASSERT_IMPL(label, ante, cons)
`define SHRP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/shrp_pkg.sv -----
// shared types, constants and the temperature conversion of the history ring pager
package shrp_pkg;

  localparam int unsigned SHRP_CAPACITY  = 1024;
  localparam int unsigned SHRP_PAGE_SIZE = 32;

  localparam logic [15:0] SAMPLE_INTERVAL_RESET = 16'd10;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_PAGE   = 1'b1;

  localparam logic signed [15:0] TEMP_INVALID = 16'sh8000;
  localparam logic signed [15:0] TEMP_HI      = 16'sd32760;
  localparam logic signed [15:0] TEMP_LO      = -16'sd32760;

  localparam int unsigned STATUS_PAUSED_BIT = 2;

  typedef struct packed {
    logic        [31:0] secs;
    logic signed [15:0] chamber;
    logic signed [15:0] heater;
    logic signed [15:0] target;
    logic        [2:0]  flags;
    logic        [7:0]  fault;
  } slot_t;

  typedef struct packed {
    logic        [31:0] now_seconds;
    logic signed [15:0] chamber_tenths;
    logic               chamber_ok;
    logic signed [15:0] heater_tenths;
    logic               heater_ok;
    logic signed [15:0] target_tenths;
    logic               work_on;
    logic        [2:0]  status_bits;
    logic        [7:0]  fault_code;
  } sample_t;

  typedef struct packed {
    logic [31:0] newest;
    logic [31:0] first;
  } hist_stat_t;

  typedef struct packed {
    logic        has_record;
    logic [31:0] seq;
    slot_t       rec;
    logic [31:0] first_seq;
    logic [31:0] newest_seq;
    logic        gap;
    logic        last;
  } page_rec_t;

  function automatic logic signed [15:0] conv_temp(input logic signed [15:0] v,
                                                   input logic ok);
    logic signed [15:0] r;
    if (ok && (v > TEMP_LO) && (v < TEMP_HI)) begin
      r = v;
    end else begin
      r = TEMP_INVALID;
    end
    return r;
  endfunction

endpackage

// ----- rtl/sequenced_history_ring_pager.sv -----
// top level of the sequenced history ring pager
`include "sequenced_history_ring_pager_macros.svh"

// A sample transaction (tuser 0) is either dropped by the interval check or
// written at once to the ring slot of its new sequence number.
// A page transaction (tuser 1) sets up the cursor in the PREP and ADDR states,
// then reads the ring memory one record per cycle through its single read port
// while the result buffer has room; results stream out at one per cycle, while
// the output accepts them, behind a two-entry buffer, and an empty page yields
// a lone marker. The next transaction is accepted once the last ring read is
// issued or the marker is pushed. Ring contents are not cleared after reset;
// only sequences already stored are ever read back.
module sequenced_history_ring_pager #(
  parameter int unsigned CAPACITY  = shrp_pkg::SHRP_CAPACITY,
  parameter int unsigned PAGE_SIZE = shrp_pkg::SHRP_PAGE_SIZE
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,       // sample_interval
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_seconds, chamber_tenths, chamber_ok, heater_tenths, heater_ok,
  // target_tenths, work_on, status_bits, fault_code, after_seq
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,    // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // seq, rec_seconds, rec_chamber, rec_heater, rec_target, rec_flags, rec_fault,
  // first_seq, newest_seq, gap
  output logic [191:0] m_axis_tdata,
  output logic         m_axis_tuser,    // has_record
  output logic         m_axis_tlast     // last_of_run
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  shrp_pkg::sample_t    sample;
  shrp_pkg::hist_stat_t stat;
  shrp_pkg::slot_t      wr_data;
  shrp_pkg::slot_t      rd_data;
  shrp_pkg::page_rec_t  m_rec;
  logic [AW-1:0]        ptr;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic                 rd_en;
  logic                 idle;
  logic                 accept;
  logic                 offer;
  logic                 page_req;

  always_comb begin
    sample.now_seconds    = s_axis_tdata[31:0];
    sample.chamber_tenths = s_axis_tdata[47:32];
    sample.chamber_ok     = s_axis_tdata[48];
    sample.heater_tenths  = s_axis_tdata[64:49];
    sample.heater_ok      = s_axis_tdata[65];
    sample.target_tenths  = s_axis_tdata[81:66];
    sample.work_on        = s_axis_tdata[82];
    sample.status_bits    = s_axis_tdata[85:83];
    sample.fault_code     = s_axis_tdata[93:86];

    s_axis_tready = idle;
    accept        = s_axis_tvalid && s_axis_tready;
    offer         = accept && (s_axis_tuser == shrp_pkg::CMD_SAMPLE);
    page_req      = accept && (s_axis_tuser == shrp_pkg::CMD_PAGE);

    m_axis_tuser = m_rec.has_record;
    m_axis_tlast = m_rec.last;
    m_axis_tdata = {4'd0, m_rec.gap, m_rec.newest_seq, m_rec.first_seq,
                    m_rec.rec.fault, m_rec.rec.flags, m_rec.rec.target,
                    m_rec.rec.heater, m_rec.rec.chamber, m_rec.rec.secs, m_rec.seq};
  end

  shrp_sample_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_sample (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .offer     (offer),
    .sample    (sample),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .stat      (stat),
    .ptr       (ptr)
  );

  shrp_ring_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  shrp_page_ctrl #(
    .CAPACITY  (CAPACITY),
    .PAGE_SIZE (PAGE_SIZE),
    .AW        (AW)
  ) u_page (
    .clk       (clk),
    .rst       (rst),
    .page_req  (page_req),
    .after_seq (s_axis_tdata[125:94]),
    .stat      (stat),
    .ptr       (ptr),
    .idle      (idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_rec     (m_rec)
  );

  // ring port is never written while a page is being read
  `SHRP_ASSERT_IMPL(a_no_write_during_read, rd_en, !wr_en)
  `SHRP_ASSERT_IMPL(a_write_only_when_idle, wr_en, idle)
  `SHRP_ASSERT_NEXT(a_write_bumps_newest, wr_en, stat.newest == $past(stat.newest) + 32'd1)

endmodule

// ----- rtl/shrp_ring_ram.sv -----
// ring storage: one write port and one registered read port
module shrp_ring_ram #(
  parameter int unsigned DEPTH = shrp_pkg::SHRP_CAPACITY,
  parameter int unsigned AW    = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  shrp_pkg::slot_t   wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output shrp_pkg::slot_t   rd_data
);

  shrp_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/shrp_sample_ctrl.sv -----
// sample admission: interval check, sequence counter, write pointer and record forming
module shrp_sample_ctrl #(
  parameter int unsigned CAPACITY = shrp_pkg::SHRP_CAPACITY,
  parameter int unsigned AW       = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  input  logic                 offer,
  input  shrp_pkg::sample_t    sample,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output shrp_pkg::slot_t      wr_data,
  output shrp_pkg::hist_stat_t stat,
  output logic [AW-1:0]        ptr
);

  logic [15:0]   interval;
  logic [31:0]   seq_count;
  logic [31:0]   last_time;
  logic          sampled_once;

  logic [31:0]   elapsed;
  logic [31:0]   seq_count_next;
  logic [AW-1:0] ptr_next;
  logic          store;

  always_comb begin
    elapsed        = sample.now_seconds - last_time;
    store          = offer && (!sampled_once || (elapsed >= {16'd0, interval}));
    seq_count_next = seq_count + 32'd1;
    // pointer follows seq_count mod capacity, restarting when the counter wraps
    if (seq_count_next == 32'd0) begin
      ptr_next = '0;
    end else if (ptr == AW'(CAPACITY - 1)) begin
      ptr_next = '0;
    end else begin
      ptr_next = ptr + AW'(1);
    end

    wr_en           = store;
    wr_addr         = ptr;
    wr_data.secs    = sample.now_seconds;
    wr_data.chamber = shrp_pkg::conv_temp(sample.chamber_tenths, sample.chamber_ok);
    wr_data.heater  = shrp_pkg::conv_temp(sample.heater_tenths, sample.heater_ok);
    if (sample.work_on && !sample.status_bits[shrp_pkg::STATUS_PAUSED_BIT]) begin
      wr_data.target = shrp_pkg::conv_temp(sample.target_tenths, 1'b1);
    end else begin
      wr_data.target = '0;
    end
    wr_data.flags = sample.status_bits;
    wr_data.fault = sample.fault_code;

    stat.newest = seq_count;
    if (seq_count > 32'(CAPACITY)) begin
      stat.first = seq_count - 32'(CAPACITY) + 32'd1;
    end else begin
      stat.first = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval     <= shrp_pkg::SAMPLE_INTERVAL_RESET;
      seq_count    <= '0;
      last_time    <= '0;
      sampled_once <= 1'b0;
      ptr          <= '0;
    end else begin
      if (cfg_we) begin
        interval <= cfg_wdata;
      end
      if (store) begin
        seq_count    <= seq_count_next;
        last_time    <= sample.now_seconds;
        sampled_once <= 1'b1;
        ptr          <= ptr_next;
      end
    end
  end

endmodule

// ----- rtl/shrp_page_ctrl.sv -----
// page sequencer: cursor setup, ring reads and a two-deep result buffer
`include "sequenced_history_ring_pager_macros.svh"

module shrp_page_ctrl #(
  parameter int unsigned CAPACITY  = shrp_pkg::SHRP_CAPACITY,
  parameter int unsigned PAGE_SIZE = shrp_pkg::SHRP_PAGE_SIZE,
  parameter int unsigned AW        = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 page_req,
  input  logic [31:0]          after_seq,
  input  shrp_pkg::hist_stat_t stat,
  input  logic [AW-1:0]        ptr,
  output logic                 idle,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  shrp_pkg::slot_t      rd_data,
  output logic                 m_valid,
  input  logic                 m_ready,
  output shrp_pkg::page_rec_t  m_rec
);

  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 1;

  typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_ADDR, ST_READ, ST_EMPTY} state_t;

  state_t        state;
  logic [31:0]   after_c;
  logic [31:0]   first_r;
  logic [31:0]   last_r;
  logic [AW-1:0] ptr_r;
  logic          gap_r;
  logic [31:0]   cur;
  logic [AW-1:0] slot_r;
  logic [CW-1:0] cnt;
  logic          inflight;
  logic [31:0]   infl_seq;
  logic          infl_last;
  logic [1:0]    occ;
  shrp_pkg::page_rec_t skid;

  logic          pop;
  logic [2:0]    room;
  logic          can_issue;
  logic          issue;
  logic          mark;
  logic          push;
  logic          issue_last;
  shrp_pkg::page_rec_t push_rec;
  logic [31:0]   first_m1;
  logic          gap_n;
  logic [31:0]   base;
  logic [31:0]   span;
  logic [SW:0]   ptr_w;
  logic [SW:0]   span_w;
  logic [SW:0]   slot_w;
  logic [AW-1:0] slot_inc;

  always_comb begin
    idle    = (state == ST_IDLE);
    m_valid = (occ != 2'd0);
    pop     = m_valid && m_ready;
    // space check counts the read in flight, since read data lands in the cycle after issue
    room      = 3'(occ) + 3'(inflight) - 3'(pop);
    can_issue = (room < 3'd2);
    issue     = (state == ST_READ) && can_issue;
    // the marker is pushed in the same cycle, so the buffer must not be full
    mark      = (state == ST_EMPTY) && (occ != 2'd2) && !inflight;
    rd_en     = issue;
    rd_addr   = slot_r;
    issue_last = (cur == last_r) || (cnt == CW'(PAGE_SIZE - 1));
    push       = inflight || mark;

    push_rec.first_seq  = first_r;
    push_rec.newest_seq = last_r;
    push_rec.gap        = gap_r;
    if (inflight) begin
      push_rec.has_record = 1'b1;
      push_rec.seq        = infl_seq;
      push_rec.rec        = rd_data;
      push_rec.last       = infl_last;
    end else begin
      push_rec.has_record = 1'b0;
      push_rec.seq        = after_c;
      push_rec.rec        = '0;
      push_rec.last       = 1'b1;
    end

    first_m1 = first_r - 32'd1;
    gap_n    = (after_c < first_m1);
    base     = gap_n ? first_m1 : after_c;

    // slot of the first record, counted back from the write pointer
    span   = last_r - cur;
    ptr_w  = (SW+1)'(ptr_r);
    span_w = (SW+1)'(span[SW-1:0]);
    if (ptr_w >= span_w) begin
      slot_w = ptr_w - span_w;
    end else begin
      slot_w = ptr_w + (SW+1)'(CAPACITY) - span_w;
    end

    if (slot_r == AW'(CAPACITY - 1)) begin
      slot_inc = '0;
    end else begin
      slot_inc = slot_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      inflight <= 1'b0;
      occ      <= 2'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (page_req) begin
            after_c <= (after_seq > stat.newest) ? 32'd0 : after_seq;
            first_r <= stat.first;
            last_r  <= stat.newest;
            ptr_r   <= ptr;
            state   <= ST_PREP;
          end
        end
        ST_PREP: begin
          gap_r <= gap_n;
          cur   <= base;
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          cnt <= '0;
          if (cur == last_r) begin
            state <= ST_EMPTY;
          end else begin
            cur    <= cur + 32'd1;
            slot_r <= slot_w[AW-1:0];
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          if (issue) begin
            cur    <= cur + 32'd1;
            slot_r <= slot_inc;
            cnt    <= cnt + CW'(1);
            if (issue_last) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMPTY: begin
          if (mark) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      inflight <= issue;
      if (issue) begin
        infl_seq  <= cur;
        infl_last <= issue_last;
      end

      // two-entry result buffer, head drives the output
      priority if (occ == 2'd2) begin
        if (pop) begin
          m_rec <= skid;
          occ   <= 2'd1;
        end
      end else if (occ == 2'd1) begin
        if (pop && push) begin
          m_rec <= push_rec;
        end else if (pop) begin
          occ <= 2'd0;
        end else if (push) begin
          skid <= push_rec;
          occ  <= 2'd2;
        end
      end else begin
        if (push) begin
          m_rec <= push_rec;
          occ   <= 2'd1;
        end
      end
    end
  end

  `SHRP_ASSERT_IMPL(a_push_has_room, push, occ != 2'd2)
  `SHRP_ASSERT_IMPL(a_cursor_in_range, state == ST_READ, cur <= last_r)
  `SHRP_ASSERT_IMPL(a_marker_ends_page, m_valid && !m_rec.has_record, m_rec.last)
  `SHRP_ASSERT_NEXT(a_read_lands, issue, inflight)

endmodule
